FILE: rtl/pala_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pala_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned HOLD_W   = 31;
	localparam int unsigned COLOR_W  = 3;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 31;

	localparam logic [HOLD_W-1:0]   HOLD_MOTION_RST  = 31'd15000;
	localparam logic [HOLD_W-1:0]   HOLD_GAS_RST     = 31'd5000;
	localparam logic [COLOR_W-1:0]  COLOR_MOTION_RST = 3'd1;
	localparam logic [COLOR_W-1:0]  COLOR_GAS_RST    = 3'd3;
	localparam logic [COLOR_W-1:0]  BASE_COLOR_RST   = 3'd0;
	localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 16'd160;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD_MOTION  = 3'd0,
		REG_HOLD_GAS     = 3'd1,
		REG_COLOR_MOTION = 3'd2,
		REG_COLOR_GAS    = 3'd3,
		REG_BASE_COLOR   = 3'd4,
		REG_BLINK_PERIOD = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		SRC_MOTION = 2'd0,
		SRC_GAS    = 2'd1,
		SRC_NONE   = 2'd2
	} src_t;

	typedef struct packed {
		logic [HOLD_W-1:0]   hold_motion;
		logic [HOLD_W-1:0]   hold_gas;
		logic [COLOR_W-1:0]  color_motion;
		logic [COLOR_W-1:0]  color_gas;
		logic [COLOR_W-1:0]  base_color;
		logic [PERIOD_W-1:0] blink_period;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] led_color;
		logic               alarm_on;
		src_t               winning_source;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/pala_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pala_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic [pala_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pala_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pala_pkg::cfg_t                           cfg
);

	pala_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_motion  <= pala_pkg::HOLD_MOTION_RST;
			cfg_q.hold_gas     <= pala_pkg::HOLD_GAS_RST;
			cfg_q.color_motion <= pala_pkg::COLOR_MOTION_RST;
			cfg_q.color_gas    <= pala_pkg::COLOR_GAS_RST;
			cfg_q.base_color   <= pala_pkg::BASE_COLOR_RST;
			cfg_q.blink_period <= pala_pkg::BLINK_PERIOD_RST;
		end else if (cfg_valid) begin
			// Indices with no register behind them are dropped.
			unique case (pala_pkg::reg_idx_t'(cfg_index))
				pala_pkg::REG_HOLD_MOTION: begin
					cfg_q.hold_motion <= cfg_data[pala_pkg::HOLD_W-1:0];
				end
				pala_pkg::REG_HOLD_GAS: begin
					cfg_q.hold_gas <= cfg_data[pala_pkg::HOLD_W-1:0];
				end
				pala_pkg::REG_COLOR_MOTION: begin
					cfg_q.color_motion <= cfg_data[pala_pkg::COLOR_W-1:0];
				end
				pala_pkg::REG_COLOR_GAS: begin
					cfg_q.color_gas <= cfg_data[pala_pkg::COLOR_W-1:0];
				end
				pala_pkg::REG_BASE_COLOR: begin
					cfg_q.base_color <= cfg_data[pala_pkg::COLOR_W-1:0];
				end
				pala_pkg::REG_BLINK_PERIOD: begin
					cfg_q.blink_period <= cfg_data[pala_pkg::PERIOD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/pala_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module pala_eval (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              advance,
	input  wire logic [pala_pkg::TIME_W-1:0]       now_ms,
	input  wire logic                              motion_flag,
	input  wire logic                              gas_flag,
	input  pala_pkg::cfg_t                         cfg,
	output pala_pkg::result_t                      result
);

	logic [pala_pkg::TIME_W-1:0] deadline_motion_q;
	logic [pala_pkg::TIME_W-1:0] deadline_gas_q;
	logic                        phase_motion_q;
	logic                        phase_gas_q;
	logic [pala_pkg::TIME_W-1:0] last_toggle_q;
	logic                        override_q;

	logic [pala_pkg::TIME_W-1:0] diff_motion;
	logic [pala_pkg::TIME_W-1:0] diff_gas;
	logic [pala_pkg::TIME_W-1:0] new_deadline_motion;
	logic [pala_pkg::TIME_W-1:0] new_deadline_gas;
	logic [pala_pkg::TIME_W-1:0] elapsed;
	logic                        ahead_motion;
	logic                        ahead_gas;
	pala_pkg::src_t              win;
	logic                        win_phase;
	logic                        toggle;
	logic                        phase_next;
	logic [pala_pkg::COLOR_W-1:0] win_color;

	assign diff_motion = deadline_motion_q - now_ms;
	assign diff_gas    = deadline_gas_q - now_ms;
	assign new_deadline_motion = now_ms + {1'b0, cfg.hold_motion};
	assign new_deadline_gas    = now_ms + {1'b0, cfg.hold_gas};

	// A fresh flag puts the deadline exactly hold ms ahead, and hold is below 2^31,
	// so it is ahead whenever hold is nonzero.
	assign ahead_motion = motion_flag ? (cfg.hold_motion != '0)
		: (diff_motion != '0) && !diff_motion[pala_pkg::TIME_W-1];
	assign ahead_gas = gas_flag ? (cfg.hold_gas != '0)
		: (diff_gas != '0) && !diff_gas[pala_pkg::TIME_W-1];

	always_comb begin
		if (ahead_motion) begin
			win = pala_pkg::SRC_MOTION;
		end else if (ahead_gas) begin
			win = pala_pkg::SRC_GAS;
		end else begin
			win = pala_pkg::SRC_NONE;
		end
	end

	assign elapsed    = now_ms - last_toggle_q;
	assign win_phase  = (win == pala_pkg::SRC_MOTION) ? phase_motion_q : phase_gas_q;
	assign win_color  = (win == pala_pkg::SRC_MOTION) ? cfg.color_motion : cfg.color_gas;
	assign toggle     = !win_phase || (elapsed >= {16'b0, cfg.blink_period});
	assign phase_next = win_phase ^ toggle;

	always_comb begin
		if (win == pala_pkg::SRC_NONE) begin
			result.led_color      = cfg.base_color;
			result.alarm_on       = 1'b0;
		end else begin
			result.led_color      = phase_next ? win_color : '0;
			result.alarm_on       = 1'b1;
		end
		result.winning_source = win;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_motion_q <= '0;
			deadline_gas_q    <= '0;
			phase_motion_q    <= 1'b0;
			phase_gas_q       <= 1'b0;
			last_toggle_q     <= '0;
			override_q        <= 1'b0;
		end else if (advance) begin
			if (motion_flag) begin
				deadline_motion_q <= new_deadline_motion;
			end
			// The walk stops at motion when it wins, so gas is left alone.
			if (gas_flag && !ahead_motion) begin
				deadline_gas_q <= new_deadline_gas;
			end
			if (win != pala_pkg::SRC_NONE) begin
				override_q <= 1'b1;
				if (toggle) begin
					last_toggle_q <= now_ms;
					if (win == pala_pkg::SRC_MOTION) begin
						phase_motion_q <= phase_next;
					end else begin
						phase_gas_q <= phase_next;
					end
				end
			end else if (override_q) begin
				override_q     <= 1'b0;
				phase_motion_q <= 1'b0;
				phase_gas_q    <= 1'b0;
				last_toggle_q  <= now_ms;
			end
		end
	end

	a_win_sets_override: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (win != pala_pkg::SRC_NONE) |=> override_q)
		else $error("override not set after a winning request");

	a_idle_clears_override: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (win == pala_pkg::SRC_NONE) |=> !override_q && !phase_motion_q && !phase_gas_q)
		else $error("alarm state not cleared after a request with no winner");

endmodule

`default_nettype wire

FILE: rtl/priority_alarm_led_annunciator.sv
`timescale 1ns / 1ps
`default_nettype none

// Priority alarm LED annunciator.
// Requests arrive on the in channel (now_ms, motion_flag, gas_flag) with
// in_valid/in_ready; results leave on the out channel (led_color, alarm_on,
// winning_source) with out_valid/out_ready. Each request gives exactly one
// result, in order. Registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high and a write lands on the edge it is taken.
// A request is captured in the input register, evaluated combinationally
// against the alarm state and moved into the result register, whose contents
// drive the outputs. One request per cycle is sustained while out_ready stays
// high; the alarm state (deadlines, blink phases, last toggle time) is
// updated in the same cycle that the request moves to the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one further request; in_ready then drops until out_ready returns.
// Asynchronous reset clears the valid flags of both registers, the alarm state
// and restores the register defaults (15000 ms, 5000 ms, red, yellow, off, 160 ms).
module priority_alarm_led_annunciator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [pala_pkg::TIME_W-1:0]        now_ms,
	input  wire logic                               motion_flag,
	input  wire logic                               gas_flag,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [pala_pkg::COLOR_W-1:0]            led_color,
	output logic                                    alarm_on,
	output logic [1:0]                              winning_source,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pala_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pala_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pala_pkg::cfg_t    cfg;
	pala_pkg::result_t result;
	pala_pkg::result_t res_s2;

	logic                        valid_s1;
	logic [pala_pkg::TIME_W-1:0] now_s1;
	logic                        motion_s1;
	logic                        gas_s1;
	logic                        valid_s2;
	logic                        advance;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	pala_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pala_eval u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.now_ms      (now_s1),
		.motion_flag (motion_s1),
		.gas_flag    (gas_s1),
		.cfg         (cfg),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1    <= now_ms;
			motion_s1 <= motion_flag;
			gas_s1    <= gas_flag;
		end
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign led_color      = res_s2.led_color;
	assign alarm_on       = res_s2.alarm_on;
	assign winning_source = res_s2.winning_source;

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register not loaded after advance");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled while a register was free");

	a_alarm_matches_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (alarm_on == (res_s2.winning_source != pala_pkg::SRC_NONE)))
		else $error("alarm_on disagrees with the winning source");

endmodule

`default_nettype wire

FILE: tb/priority_alarm_led_annunciator_tb.sv
`timescale 1ns / 1ps

module priority_alarm_led_annunciator_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD_OFF = 150;
	localparam int MAX_REPORTS = 10;
	// Indexes beyond the register file; writes to them must change nothing.
	localparam logic [pala_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [pala_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef logic [pala_pkg::CFG_DATA_W-1:0] cfg_word_t;

	typedef struct packed {
		logic [pala_pkg::TIME_W-1:0] now;
		logic                        motion;
		logic                        gas;
	} poll_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [pala_pkg::TIME_W-1:0] now_ms = '0;
	logic motion_flag = 1'b0;
	logic gas_flag = 1'b0;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [pala_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pala_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic in_ready;
	logic out_valid;
	logic [pala_pkg::COLOR_W-1:0] led_color;
	logic alarm_on;
	logic [1:0] winning_source;
	logic cfg_ready;

	priority_alarm_led_annunciator u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.now_ms         (now_ms),
		.motion_flag    (motion_flag),
		.gas_flag       (gas_flag),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.led_color      (led_color),
		.alarm_on       (alarm_on),
		.winning_source (winning_source),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow of the annunciator: registers and alarm state.
	logic [pala_pkg::HOLD_W-1:0]   sh_hold_motion  = pala_pkg::HOLD_MOTION_RST;
	logic [pala_pkg::HOLD_W-1:0]   sh_hold_gas     = pala_pkg::HOLD_GAS_RST;
	logic [pala_pkg::COLOR_W-1:0]  sh_color_motion = pala_pkg::COLOR_MOTION_RST;
	logic [pala_pkg::COLOR_W-1:0]  sh_color_gas    = pala_pkg::COLOR_GAS_RST;
	logic [pala_pkg::COLOR_W-1:0]  sh_base_color   = pala_pkg::BASE_COLOR_RST;
	logic [pala_pkg::PERIOD_W-1:0] sh_blink_period = pala_pkg::BLINK_PERIOD_RST;
	logic [pala_pkg::TIME_W-1:0]   sh_deadline [2] = '{default: '0};
	logic                          sh_phase [2]    = '{default: 1'b0};
	logic [pala_pkg::TIME_W-1:0]   sh_last_toggle  = '0;
	logic                          sh_override     = 1'b0;

	poll_t             poll_q [$];
	pala_pkg::result_t led_expect_q [$];

	logic [pala_pkg::TIME_W-1:0] tick = '0;
	bit no_idle = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_off_left = 0;
	int hold_off_asks = 0;
	int hold_off_taken = 0;
	int fail_count = 0;
	int polls_sent = 0;
	int results_seen = 0;
	int motion_wins = 0;
	int gas_wins = 0;
	int quiet_polls = 0;
	int writes_done = 0;
	int cycle_count = 0;

	function automatic pala_pkg::result_t annunciate(poll_t p);
		pala_pkg::result_t r;
		logic [pala_pkg::TIME_W-1:0] diff;
		logic [pala_pkg::TIME_W-1:0] hold;
		logic flag;
		int win;
		win = 2;
		for (int i = 0; i < 2; i++) begin
			if (win == 2) begin
				flag = (i == 0) ? p.motion : p.gas;
				hold = (i == 0) ? {1'b0, sh_hold_motion} : {1'b0, sh_hold_gas};
				if (flag)
					sh_deadline[i] = p.now + hold;
				diff = sh_deadline[i] - p.now;
				// Ahead means a nonzero distance in the forward half of the wrap.
				if (diff != '0 && !diff[pala_pkg::TIME_W-1])
					win = i;
			end
		end
		if (win < 2) begin
			sh_override = 1'b1;
			diff = p.now - sh_last_toggle;
			if (!sh_phase[win] || diff >= {16'd0, sh_blink_period}) begin
				sh_last_toggle = p.now;
				sh_phase[win] = ~sh_phase[win];
			end
			if (sh_phase[win])
				r.led_color = (win == 0) ? sh_color_motion : sh_color_gas;
			else
				r.led_color = '0;
			r.alarm_on = 1'b1;
			r.winning_source = (win == 0) ? pala_pkg::SRC_MOTION : pala_pkg::SRC_GAS;
		end else begin
			if (sh_override) begin
				sh_override = 1'b0;
				sh_phase[0] = 1'b0;
				sh_phase[1] = 1'b0;
				sh_last_toggle = p.now;
			end
			r.led_color = sh_base_color;
			r.alarm_on = 1'b0;
			r.winning_source = pala_pkg::SRC_NONE;
		end
		return r;
	endfunction

	// Request driver.
	always @(posedge clk) begin : poll_driver
		if (arst_n) begin
			if (in_valid && in_ready) begin
				led_expect_q.push_back(annunciate(poll_q.pop_front()));
				polls_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (poll_q.size() != 0 && !no_idle && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 4);
					in_valid <= 1'b0;
				end else if (poll_q.size() != 0) begin
					in_valid <= 1'b1;
					now_ms <= poll_q[0].now;
					motion_flag <= poll_q[0].motion;
					gas_flag <= poll_q[0].gas;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk) begin : led_monitor
		pala_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (led_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result: led %0d alarm %0d src %0d",
							led_color, alarm_on, winning_source);
				end else begin
					want = led_expect_q.pop_front();
					case (want.winning_source)
						pala_pkg::SRC_MOTION: motion_wins++;
						pala_pkg::SRC_GAS:    gas_wins++;
						default:              quiet_polls++;
					endcase
					if (led_color !== want.led_color || alarm_on !== want.alarm_on ||
					    winning_source !== want.winning_source) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"result %0d: expected led %0d alarm %0d src %0d, ",
								"got led %0d alarm %0d src %0d"},
								results_seen, want.led_color, want.alarm_on,
								want.winning_source, led_color, alarm_on, winning_source);
					end
				end
			end
			if (hold_off_asks != hold_off_taken) begin
				hold_off_taken++;
				hold_off_left = LONG_HOLD_OFF;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("priority_alarm_led_annunciator regression: fail");
			$finish;
		end
	end

	task automatic add_poll(input logic [pala_pkg::TIME_W-1:0] t, input logic m,
		input logic g);
		poll_t p;
		p.now = t;
		p.motion = m;
		p.gas = g;
		poll_q.push_back(p);
	endtask

	// Returns at a rising edge once every request has been taken and answered.
	task automatic settle();
		do
			@(posedge clk);
		while (poll_q.size() != 0 || in_valid || led_expect_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after its last write.
	task automatic cfg_write(input logic [pala_pkg::CFG_IDX_W-1:0] idx,
		input logic [pala_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			pala_pkg::REG_HOLD_MOTION:  sh_hold_motion = data;
			pala_pkg::REG_HOLD_GAS:     sh_hold_gas = data;
			pala_pkg::REG_COLOR_MOTION: sh_color_motion = data[pala_pkg::COLOR_W-1:0];
			pala_pkg::REG_COLOR_GAS:    sh_color_gas = data[pala_pkg::COLOR_W-1:0];
			pala_pkg::REG_BASE_COLOR:   sh_base_color = data[pala_pkg::COLOR_W-1:0];
			pala_pkg::REG_BLINK_PERIOD: sh_blink_period = data[pala_pkg::PERIOD_W-1:0];
			default: ;
		endcase
		writes_done++;
	endtask

	task automatic random_setup();
		cfg_write(pala_pkg::REG_HOLD_MOTION, cfg_word_t'($urandom_range(0, 3000)));
		cfg_write(pala_pkg::REG_HOLD_GAS, cfg_word_t'($urandom_range(0, 3000)));
		cfg_write(pala_pkg::REG_COLOR_MOTION, cfg_word_t'($urandom()));
		cfg_write(pala_pkg::REG_COLOR_GAS, cfg_word_t'($urandom()));
		cfg_write(pala_pkg::REG_BASE_COLOR, cfg_word_t'($urandom()));
		// Upper bits are junk that the period register must drop.
		cfg_write(pala_pkg::REG_BLINK_PERIOD,
			cfg_word_t'(($urandom() & 32'h7FFF0000) | $urandom_range(0, 400)));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_random_polls(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				tick = $urandom();
			else if (r < 4)
				tick += $urandom_range(0, 3000);
			else
				tick += $urandom_range(0, 200);
			add_poll(tick, $urandom_range(0, 9) == 0, $urandom_range(0, 6) == 0);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Register defaults: boundary of the forward half, the reset deadline
		// winning without a flag, blink timing, wrap of now, priority walk.
		add_poll(32'h0000_0000, 1'b0, 1'b0);
		add_poll(32'h8000_0000, 1'b0, 1'b0);
		add_poll(32'h8000_0001, 1'b0, 1'b0);
		add_poll(32'h8000_0002, 1'b0, 1'b0);
		add_poll(32'h8000_00A1, 1'b0, 1'b0);
		add_poll(32'h8000_00A2, 1'b0, 1'b0);
		add_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
		add_poll(32'd14999, 1'b0, 1'b0);
		add_poll(32'd15000, 1'b0, 1'b1);
		add_poll(32'd15001, 1'b0, 1'b0);
		add_poll(32'd15002, 1'b1, 1'b0);
		add_poll(32'd15003, 1'b1, 1'b1);
		settle();

		// Zero motion hold, longest gas hold, blink on every poll.
		cfg_write(pala_pkg::REG_HOLD_MOTION, 31'd0);
		cfg_write(pala_pkg::REG_HOLD_GAS, 31'h7FFF_FFFF);
		cfg_write(pala_pkg::REG_COLOR_MOTION, 31'h7FFF_FFFF);
		cfg_write(pala_pkg::REG_COLOR_GAS, 31'd0);
		cfg_write(pala_pkg::REG_BASE_COLOR, 31'd7);
		cfg_write(pala_pkg::REG_BLINK_PERIOD, 31'd0);
		cfg_write(REG_SPARE_6, cfg_word_t'($urandom()));
		cfg_write(REG_SPARE_7, cfg_word_t'($urandom()));
		cfg_valid <= 1'b0;
		@(negedge clk);
		add_poll(32'd40000, 1'b1, 1'b0);
		add_poll(32'd40001, 1'b0, 1'b1);
		add_poll(32'd40002, 1'b0, 1'b0);
		add_poll(32'd40003, 1'b0, 1'b0);
		add_poll(32'd40004, 1'b1, 1'b0);
		add_poll(32'd40005, 1'b0, 1'b0);
		settle();

		// Longest motion hold, zero gas hold, longest blink period.
		cfg_write(pala_pkg::REG_HOLD_MOTION, 31'h7FFF_FFFF);
		cfg_write(pala_pkg::REG_HOLD_GAS, 31'd0);
		cfg_write(pala_pkg::REG_COLOR_GAS, 31'd6);
		cfg_write(pala_pkg::REG_BLINK_PERIOD, 31'h7FFF_FFFF);
		cfg_valid <= 1'b0;
		@(negedge clk);
		add_poll(32'd50000, 1'b1, 1'b1);
		add_poll(32'd115534, 1'b0, 1'b0);
		add_poll(32'd115535, 1'b0, 1'b0);
		add_poll(32'd115536, 1'b0, 1'b0);
		add_poll(32'h8000_C350, 1'b0, 1'b1);
		settle();

		tick = $urandom();
		random_setup();
		queue_random_polls(100);
		settle();

		// The receiver stops for a long stretch while requests keep coming.
		random_setup();
		hold_off_asks++;
		queue_random_polls(100);
		settle();

		random_setup();
		queue_random_polls(100);
		settle();

		random_setup();
		no_idle = 1'b1;
		queue_random_polls(100);
		settle();

		repeat (8) @(posedge clk);
		$display("Sent %0d polls across %0d register writes;",
			polls_sent, writes_done);
		$display("motion won %0d, gas won %0d, idle %0d.",
			motion_wins, gas_wins, quiet_polls);
		if (fail_count == 0 && led_expect_q.size() == 0)
			$display("priority_alarm_led_annunciator regression: pass");
		else
			$display("priority_alarm_led_annunciator regression: fail");
		$finish;
	end

endmodule

FILE: files.f
rtl/pala_pkg.sv
rtl/pala_cfg_regs.sv
rtl/pala_eval.sv
rtl/priority_alarm_led_annunciator.sv
tb/priority_alarm_led_annunciator_tb.sv
